[sv/defective_pixel_mean_fill_macros.svh]
// Assertion macros for the defective pixel mean fill RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef DEFECTIVE_PIXEL_MEAN_FILL_MACROS_SVH
`define DEFECTIVE_PIXEL_MEAN_FILL_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DPMF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DPMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[sv/dpmf_pkg.sv]
// Package for the defective pixel mean fill block: types and constants.
// Depends on nothing; imported by all modules of the block but dpmf_ram.
`timescale 1ns / 1ps
package dpmf_pkg;
   localparam int PixW  = 16;
   localparam int RowW  = 16;
   localparam int ColW  = 10;
   localparam int CsrAW = 3;
   localparam logic [CsrAW-1:0] AddrWidth  = 3'd0;
   localparam logic [CsrAW-1:0] AddrHeight = 3'd4;

   // One classified job handed from the front to the back.
   typedef struct packed {
      logic [PixW-1:0] centre;
      logic            fix;        // defective interior centre
      logic [PixW-1:0] nb0, nb1, nb2, nb3, nb4, nb5, nb6, nb7;
      logic            emit_a;     // (r-1, c-1)
      logic            emit_b;     // (r-1, W-1) from middle line
      logic            emit_c;     // (r, c) on last row
      logic [PixW-1:0] mid;
      logic [PixW-1:0] cur;
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
   } job_type;

   // One result item.
   typedef struct packed {
      logic [PixW-1:0] pix;
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      logic            last;
   } rsp_type;
endpackage

[sv/defective_pixel_mean_fill.sv]
// Top level of the defective pixel mean fill block with its register port.
// Depends on dpmf_pkg, dpmf_front, dpmf_queue and dpmf_back.
//
// Pixels enter on req_ (req_pixel_in, signed Q7.8) in raster order; negative
// pixels are defective. Each interior defective pixel is replaced by the
// truncated mean of its non-negative neighbours, zero if none; the others
// pass unchanged. Results leave on rsp_ with their row and column, and
// rsp_last_of_run marks the final result an item caused (up to three).
// The front reads the two line stores for a pixel in READ, waits for the
// registered read data in WAIT and takes the item in WORK, so it cannot
// accept a new item until it has passed through all three states. The back
// takes a job in IDLE; for a fixed pixel it then sums the eight neighbours
// in SUM and divides in DIV. It spends one slot per possible result in A, B
// and C, and takes no new job until it is back in IDLE. A two-entry queue
// sits between front and back so either side may stall. Registers:
// image_width at 0x0, image_height at 0x4; a write to either restarts the
// frame at row 0, column 0. Reset clears position, window and registers to
// 1024 by 1024; line store contents stay undefined until written, and never
// reach an output. A stalled receiver holds rsp_ steady and backs up the
// queue, then the front.
`timescale 1ns / 1ps
module defective_pixel_mean_fill import dpmf_pkg::*; #(
   parameter int MaxWidth = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [15:0] req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [15:0] rsp_pixel_out,
   output logic [15:0]       rsp_row_index,
   output logic [9:0]        rsp_column_index,
   output logic              rsp_last_of_run,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CsrAW-1:0]  paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic        wr;
   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   job_type     fq_job, qb_job;
   rsp_type     rsp;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 16'd1024;
      end else if (wr) begin
         unique case (paddr)
            AddrWidth:  width_ff  <= pwdata[10:0];
            AddrHeight: height_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         AddrWidth:  prdata = {21'd0, width_ff};
         AddrHeight: prdata = {16'd0, height_ff};
         default:    prdata = '0;
      endcase
   end

   dpmf_front #(.MaxWidth(MaxWidth)) u_front (
      .clock(clock), .reset(reset),
      .restart(wr && (paddr == AddrWidth || paddr == AddrHeight)),
      .width_cfg(width_ff), .height_cfg(height_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_pix(req_pixel_in),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job));

   dpmf_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job));

   dpmf_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp));

   assign rsp_pixel_out    = rsp.pix;
   assign rsp_row_index    = rsp.row;
   assign rsp_column_index = rsp.col;
   assign rsp_last_of_run  = rsp.last;
endmodule

[sv/dpmf_ram.sv]
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module dpmf_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      if (re) rdata <= mem[addr];
   end
endmodule

[sv/dpmf_front.sv]
// Front of the mean fill block: position tracking, line stores and window.
// Depends on dpmf_pkg and dpmf_ram; builds one job per accepted pixel.
`timescale 1ns / 1ps
module dpmf_front import dpmf_pkg::*; #(
   parameter int MaxWidth = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            restart,
   input  logic [10:0]     width_cfg,
   input  logic [15:0]     height_cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [PixW-1:0] in_pix,
   output logic            job_valid,
   input  logic            job_ready,
   output job_type         job
);
   localparam int AW = $clog2(MaxWidth);
   localparam int WW = AW + 1;

   // READ fetches the line stores at column c, WAIT lets the registered read
   // data arrive, and WORK forms the job once the item is taken.
   typedef enum logic [1:0] {S_READ, S_WAIT, S_WORK} state_type;
   state_type state_ff, state_in;

   logic [RowW-1:0] row_ff, row_in;
   logic [WW-1:0]   col_ff, col_in;
   logic [PixW-1:0] tap_ff [6];
   logic [PixW-1:0] up_rd, mid_rd;
   logic [WW-1:0]   w_eff;
   logic [RowW-1:0] h_eff;
   logic [WW-1:0]   c_use;
   logic [RowW-1:0] r_use;
   logic            take;

   always_comb begin
      if (width_cfg == '0) w_eff = WW'(1);
      else if (32'(width_cfg) > 32'(MaxWidth)) w_eff = WW'(MaxWidth);
      else w_eff = WW'(width_cfg);
      h_eff = (height_cfg == '0) ? RowW'(1) : height_cfg;
      c_use = (col_ff >= w_eff) ? '0 : col_ff;
      r_use = (row_ff >= h_eff) ? '0 : row_ff;
   end

   assign take     = (state_ff == S_WORK) && in_valid && job_ready;
   assign in_ready = take;

   dpmf_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
      .clock(clock), .we(take), .addr(c_use[AW-1:0]), .wdata(mid_rd),
      .re(state_ff == S_READ), .rdata(up_rd));
   dpmf_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
      .clock(clock), .we(take), .addr(c_use[AW-1:0]), .wdata(in_pix),
      .re(state_ff == S_READ), .rdata(mid_rd));

   always_comb begin
      logic [PixW-1:0] ctr;
      ctr = tap_ff[1];
      job = '0;
      job.centre = ctr;
      job.fix    = (r_use >= RowW'(2)) && (c_use >= WW'(2)) && ctr[PixW-1];
      job.nb0 = tap_ff[3]; job.nb1 = tap_ff[4]; job.nb2 = tap_ff[5];
      job.nb3 = tap_ff[0]; job.nb4 = tap_ff[2];
      job.nb5 = up_rd; job.nb6 = mid_rd; job.nb7 = in_pix;
      job.emit_a = (r_use != '0) && (c_use != '0);
      job.emit_b = (r_use != '0) && (c_use == w_eff - WW'(1));
      job.emit_c = (r_use == h_eff - RowW'(1));
      job.mid = mid_rd;
      job.cur = in_pix;
      job.row = r_use;
      job.col = ColW'(c_use);
      job_valid = take;
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      unique case (state_ff)
         S_READ: state_in = S_WAIT;
         S_WAIT: state_in = S_WORK;
         S_WORK: if (take) begin
            state_in = S_READ;
            if (c_use >= w_eff - WW'(1)) begin
               col_in = '0;
               row_in = (r_use >= h_eff - RowW'(1)) ? '0 : r_use + RowW'(1);
            end else begin
               col_in = c_use + WW'(1);
               row_in = r_use;
            end
         end
         default: state_in = S_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= S_READ;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
      if (reset) begin
         for (int i = 0; i < 6; i++) tap_ff[i] <= '0;
      end else if (take) begin
         tap_ff[3] <= tap_ff[0];
         tap_ff[4] <= tap_ff[1];
         tap_ff[5] <= tap_ff[2];
         tap_ff[0] <= up_rd;
         tap_ff[1] <= mid_rd;
         tap_ff[2] <= in_pix;
      end
   end
endmodule

[sv/dpmf_queue.sv]
// Two-entry job queue between front and back.
// Depends on dpmf_pkg.
`timescale 1ns / 1ps
module dpmf_queue import dpmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_data
);
   job_type    slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = slot_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wp_ff] <= wr_data;
   end
endmodule

[sv/dpmf_back.sv]
// Back of the mean fill block: neighbour mean by serial division, emission.
// Depends on dpmf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "defective_pixel_mean_fill_macros.svh"
module dpmf_back import dpmf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   output logic            job_ready,
   input  job_type         job,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp
);
   typedef enum logic [2:0] {S_IDLE, S_SUM, S_DIV, S_A, S_B, S_C} state_type;
   state_type state_ff;
   job_type   job_ff;
   logic [17:0] rem_ff;      // sum of up to eight 15-bit values
   logic [3:0]  cnt_ff;
   logic [3:0]  idx_ff;
   logic [17:0] quo_ff;
   logic [4:0]  bit_ff;
   logic        out_valid_ff;
   rsp_type     out_ff;

   logic [PixW-1:0] nb_sel;
   logic            ovf_free;

   always_comb begin
      unique case (idx_ff[2:0])
         3'd0: nb_sel = job_ff.nb0;
         3'd1: nb_sel = job_ff.nb1;
         3'd2: nb_sel = job_ff.nb2;
         3'd3: nb_sel = job_ff.nb3;
         3'd4: nb_sel = job_ff.nb4;
         3'd5: nb_sel = job_ff.nb5;
         3'd6: nb_sel = job_ff.nb6;
         default: nb_sel = job_ff.nb7;
      endcase
   end

   assign ovf_free  = !out_valid_ff || rsp_ready;
   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      logic [18:0] trial;
      logic        more_b, more_c;
      logic        out_valid_in;
      trial  = {rem_ff, quo_ff[17]} - {15'd0, cnt_ff};
      more_b = job_ff.emit_b || job_ff.emit_c;
      more_c = job_ff.emit_c;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               job_ff   <= job;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               idx_ff   <= '0;
               state_ff <= job.fix ? S_SUM : S_A;
            end
            S_SUM: begin
               idx_ff <= idx_ff + 4'd1;
               if (idx_ff == 4'd7) begin
                  // The last neighbour goes straight into the dividend.
                  quo_ff   <= rem_ff + (nb_sel[PixW-1] ? 18'd0 : 18'(nb_sel));
                  rem_ff   <= '0;
                  if (!nb_sel[PixW-1]) cnt_ff <= cnt_ff + 4'd1;
                  bit_ff   <= '0;
                  state_ff <= S_DIV;
               end else if (!nb_sel[PixW-1]) begin
                  rem_ff <= rem_ff + 18'(nb_sel);
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            S_DIV: begin
               // Restoring division, one quotient bit per cycle.
               if (!trial[18] && cnt_ff != '0) begin
                  rem_ff <= trial[17:0];
                  quo_ff <= {quo_ff[16:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[16:0], quo_ff[17]};
                  quo_ff <= {quo_ff[16:0], 1'b0};
               end
               bit_ff <= bit_ff + 5'd1;
               if (bit_ff == 5'd17) begin
                  state_ff <= S_A;
               end
            end
            S_A: if (ovf_free) begin
               if (job_ff.emit_a) begin
                  out_valid_in = 1'b1;
                  out_ff.pix  <= job_ff.fix ?
                     ((cnt_ff == '0) ? '0 : quo_ff[PixW-1:0]) : job_ff.centre;
                  out_ff.row  <= job_ff.row - RowW'(1);
                  out_ff.col  <= job_ff.col - ColW'(1);
                  out_ff.last <= !more_b;
               end
               state_ff <= S_B;
            end
            S_B: if (ovf_free || !job_ff.emit_a) begin
               if (job_ff.emit_b) begin
                  out_valid_in = 1'b1;
                  out_ff.pix  <= job_ff.mid;
                  out_ff.row  <= job_ff.row - RowW'(1);
                  out_ff.col  <= job_ff.col;
                  out_ff.last <= !more_c;
               end
               state_ff <= S_C;
            end
            S_C: if (ovf_free || !(job_ff.emit_a || job_ff.emit_b)) begin
               if (job_ff.emit_c) begin
                  out_valid_in = 1'b1;
                  out_ff.pix  <= job_ff.cur;
                  out_ff.row  <= job_ff.row;
                  out_ff.col  <= job_ff.col;
                  out_ff.last <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         out_valid_ff <= out_valid_in;
      end
   end

   `DPMF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
   `DPMF_ASSERT_IMP(a_cnt, clock, reset, state_ff == S_DIV, cnt_ff <= 4'd8, "neighbour count above eight")
   `DPMF_ASSERT_IMP(a_take, clock, reset, job_valid && job_ready, state_ff == S_IDLE, "job taken while busy")
endmodule
